/* rtl/ascd_pkg.sv */
`timescale 1ns / 1ps

package ascd_pkg;

    localparam int DEF_HISTORY_DEPTH = 5;
    localparam int DEF_ADC_BITS      = 10;

    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int OUT_W      = 8;
    localparam int LEVEL_W    = 2;

    // Axis scale factor and the number of multiplier passes (three axes plus a flush).
    localparam int AXIS_SCALE = 10;
    localparam int MUL_STEPS  = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_CLASH_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SWING_SMALL     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SWING_MEDIUM    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SWING_LARGE     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_CLASH_HOLDOFF   = 3'd4;

    localparam logic [CFG_DATA_W-1:0] RST_CLASH_THRESHOLD = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] RST_SWING_SMALL     = 16'd20;
    localparam logic [CFG_DATA_W-1:0] RST_SWING_MEDIUM    = 16'd40;
    localparam logic [CFG_DATA_W-1:0] RST_SWING_LARGE     = 16'd80;
    localparam logic [CFG_DATA_W-1:0] RST_CLASH_HOLDOFF   = 16'd100;

    localparam logic [LEVEL_W-1:0] LEVEL_SMALL  = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MEDIUM = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_LARGE  = 2'd2;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic root_step;
        logic div_init;
        logic div_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic dup;
        logic have_sample;
        logic scan_busy;
        logic out_free;
    } status_t;

endpackage

/* rtl/ascd_ctrl.sv */
`timescale 1ns / 1ps

module ascd_ctrl #(
    parameter int ADC_BITS = ascd_pkg::DEF_ADC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ascd_pkg::status_t status,
    output ascd_pkg::cmd_t    cmd
);

    localparam int STEPS  = ADC_BITS + 5;
    localparam int STEP_W = $clog2(STEPS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_DINIT = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && !status.dup)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = STEP_W'(ascd_pkg::MUL_STEPS - 1);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = STEP_W'(STEPS - 1);
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = status.have_sample ? S_DINIT : S_DONE;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = STEP_W'(STEPS - 1);
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free && !status.scan_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* rtl/ascd_datapath.sv */
`timescale 1ns / 1ps

module ascd_datapath #(
    parameter int HISTORY_DEPTH = ascd_pkg::DEF_HISTORY_DEPTH,
    parameter int ADC_BITS      = ascd_pkg::DEF_ADC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [ascd_pkg::TIME_W-1:0]         sample_time,
    input  logic [ADC_BITS-1:0]                 accel_x,
    input  logic [ADC_BITS-1:0]                 accel_y,
    input  logic [ADC_BITS-1:0]                 accel_z,
    input  logic                                cfg_we,
    input  logic [ascd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ascd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  ascd_pkg::cmd_t                      cmd,
    output ascd_pkg::status_t                   status,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic                                clash,
    output logic                                swing,
    output logic [ascd_pkg::LEVEL_W-1:0]        swing_level
);

    localparam int SCALED_W = ADC_BITS + 4;
    localparam int SQ_W     = 2 * SCALED_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int MAG_W    = SCALED_W + 1;
    localparam int SLOTS    = HISTORY_DEPTH - 1;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int CMP_W    = (MAG_W > ascd_pkg::CFG_DATA_W) ? MAG_W : ascd_pkg::CFG_DATA_W;
    localparam int TW       = ascd_pkg::TIME_W;
    localparam int DW       = ascd_pkg::CFG_DATA_W;

    logic [DW-1:0] thr_reg, small_reg, medium_reg, large_reg, holdoff_reg;

    logic [TW-1:0]       time_reg, elapsed_reg;
    logic [SCALED_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [SQ_W-1:0]     prod_reg;
    logic [SUM_W-1:0]    acc_reg;
    logic [MAG_W:0]      rem_reg;
    logic [MAG_W-1:0]    root_reg;
    logic [MAG_W-1:0]    q_reg;
    logic [MAG_W-1:0]    r_reg;

    logic [MAG_W-1:0] rates_reg [SLOTS];
    logic [CNT_W-1:0] rate_cnt_reg;
    logic             have_sample_reg;
    logic [MAG_W-1:0] last_mag_reg;
    logic [TW-1:0]    last_time_reg;
    logic [TW-1:0]    last_clash_reg;
    logic [ascd_pkg::LEVEL_W-1:0] level_reg;

    logic             scan_busy_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             scan_all_reg;
    logic [MAG_W-1:0] scan_peak_reg;

    logic             out_valid_reg;
    logic             out_clash_reg;
    logic             out_swing_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= ascd_pkg::RST_CLASH_THRESHOLD;
            small_reg   <= ascd_pkg::RST_SWING_SMALL;
            medium_reg  <= ascd_pkg::RST_SWING_MEDIUM;
            large_reg   <= ascd_pkg::RST_SWING_LARGE;
            holdoff_reg <= ascd_pkg::RST_CLASH_HOLDOFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                ascd_pkg::REG_CLASH_THRESHOLD: thr_reg     <= cfg_wdata;
                ascd_pkg::REG_SWING_SMALL:     small_reg   <= cfg_wdata;
                ascd_pkg::REG_SWING_MEDIUM:    medium_reg  <= cfg_wdata;
                ascd_pkg::REG_SWING_LARGE:     large_reg   <= cfg_wdata;
                ascd_pkg::REG_CLASH_HOLDOFF:   holdoff_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign status.dup         = have_sample_reg && (sample_time == last_time_reg);
    assign status.have_sample = have_sample_reg;
    assign status.scan_busy   = scan_busy_reg;
    assign status.out_free    = !out_valid_reg || out_ready;

    // Integer square root, one result bit per step.
    logic [MAG_W+2:0] rem_sh;
    logic [MAG_W+1:0] root_trial;
    logic [MAG_W+2:0] rem_sub;
    logic             root_ge;

    assign rem_sh     = {rem_reg, acc_reg[SUM_W-1 -: 2]};
    assign root_trial = {root_reg, 2'b01};
    assign root_ge    = rem_sh >= {1'b0, root_trial};
    assign rem_sub    = rem_sh - {1'b0, root_trial};

    // Restoring divider, one quotient bit per step.
    logic [MAG_W:0]   div_trial;
    logic             div_ge;
    logic [MAG_W:0]   div_sub;
    logic [MAG_W-1:0] mag_diff;

    assign div_trial = {r_reg, q_reg[MAG_W-1]};
    assign div_ge    = TW'(div_trial) >= elapsed_reg;
    assign div_sub   = div_trial - elapsed_reg[MAG_W:0];
    assign mag_diff  = (root_reg >= last_mag_reg) ? (root_reg - last_mag_reg)
                                                  : (last_mag_reg - root_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            time_reg    <= sample_time;
            elapsed_reg <= sample_time - last_time_reg;
            sx_reg      <= SCALED_W'(accel_x) * SCALED_W'(ascd_pkg::AXIS_SCALE);
            sy_reg      <= SCALED_W'(accel_y) * SCALED_W'(ascd_pkg::AXIS_SCALE);
            sz_reg      <= SCALED_W'(accel_z) * SCALED_W'(ascd_pkg::AXIS_SCALE);
            prod_reg    <= '0;
            acc_reg     <= '0;
            rem_reg     <= '0;
            root_reg    <= '0;
        end
        else if (cmd.mul_step)
        begin
            prod_reg <= sx_reg * sx_reg;
            sx_reg   <= sy_reg;
            sy_reg   <= sz_reg;
            sz_reg   <= '0;
            acc_reg  <= acc_reg + SUM_W'(prod_reg);
        end
        else if (cmd.root_step)
        begin
            acc_reg  <= acc_reg << 2;
            rem_reg  <= root_ge ? rem_sub[MAG_W:0] : rem_sh[MAG_W:0];
            root_reg <= {root_reg[MAG_W-2:0], root_ge};
        end

        if (cmd.div_init)
        begin
            q_reg <= mag_diff;
            r_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            q_reg <= {q_reg[MAG_W-2:0], div_ge};
            r_reg <= div_ge ? div_sub[MAG_W-1:0] : div_trial[MAG_W-1:0];
        end
    end

    // Pass over the older rates that stay in the history, run from the load while the magnitude is worked out.
    logic [CNT_W-1:0] scan_limit;
    logic [MAG_W-1:0] scan_val;

    assign scan_limit = (rate_cnt_reg < CNT_W'(SLOTS)) ? rate_cnt_reg : CNT_W'(SLOTS - 1);
    assign scan_val   = rates_reg[scan_idx_reg[IDX_W-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_busy_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            scan_busy_reg <= 1'b1;
        end
        else if (scan_busy_reg && (scan_idx_reg >= scan_limit))
        begin
            scan_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            scan_idx_reg  <= '0;
            scan_all_reg  <= 1'b1;
            scan_peak_reg <= '0;
        end
        else if (scan_busy_reg && (scan_idx_reg < scan_limit))
        begin
            scan_idx_reg <= scan_idx_reg + 1'b1;
            if (CMP_W'(scan_val) < CMP_W'(small_reg))
            begin
                scan_all_reg <= 1'b0;
            end
            if (scan_val > scan_peak_reg)
            begin
                scan_peak_reg <= scan_val;
            end
        end
    end

    // Decision on the finished sample.
    logic [MAG_W-1:0] new_rate;
    logic [MAG_W-1:0] peak;
    logic             all_small;
    logic [TW-1:0]    since;
    logic             clash_hit;
    logic             swing_hit;
    logic [ascd_pkg::LEVEL_W-1:0] level_new;

    assign new_rate  = q_reg;
    assign all_small = scan_all_reg && (CMP_W'(new_rate) >= CMP_W'(small_reg));
    assign peak      = (new_rate > scan_peak_reg) ? new_rate : scan_peak_reg;
    assign since     = time_reg - last_clash_reg;
    assign clash_hit = have_sample_reg && (CMP_W'(new_rate) > CMP_W'(thr_reg))
                       && (since >= TW'(holdoff_reg));
    assign swing_hit = have_sample_reg && !clash_hit && (since > TW'(holdoff_reg))
                       && all_small;

    always_comb
    begin
        level_new = ascd_pkg::LEVEL_SMALL;
        if (CMP_W'(peak) >= CMP_W'(medium_reg))
        begin
            level_new = ascd_pkg::LEVEL_MEDIUM;
        end
        if (CMP_W'(peak) >= CMP_W'(large_reg))
        begin
            level_new = ascd_pkg::LEVEL_LARGE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_sample_reg <= 1'b0;
            rate_cnt_reg    <= '0;
            last_mag_reg    <= '0;
            last_time_reg   <= '0;
            last_clash_reg  <= '0;
            level_reg       <= ascd_pkg::LEVEL_SMALL;
        end
        else if (cmd.commit)
        begin
            have_sample_reg <= 1'b1;
            last_mag_reg    <= root_reg;
            last_time_reg   <= time_reg;
            if (have_sample_reg && (rate_cnt_reg < CNT_W'(SLOTS)))
            begin
                rate_cnt_reg <= rate_cnt_reg + 1'b1;
            end
            if (clash_hit)
            begin
                last_clash_reg <= time_reg;
            end
            if (swing_hit)
            begin
                level_reg <= level_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && have_sample_reg)
        begin
            for (int i = SLOTS - 1; i > 0; i--)
            begin
                rates_reg[i] <= rates_reg[i-1];
            end
            rates_reg[0] <= new_rate;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_clash_reg <= clash_hit;
            out_swing_reg <= swing_hit;
        end
    end

    assign out_valid   = out_valid_reg;
    assign clash       = out_clash_reg;
    assign swing       = out_swing_reg;
    assign swing_level = level_reg;

endmodule

/* rtl/accel_swing_clash_detector_core.sv */
`timescale 1ns / 1ps

// Swing and clash detector for timestamped 3-axis accelerometer samples. Each
// sample transfer on the input stream gives one result transfer, except a sample
// whose timestamp repeats the last accepted one, which is taken and dropped. A
// sample occupies the block from acceptance to commit: passes on the shared
// squaring multiplier over the three axes, one result bit per cycle in the
// square-root unit, a step to start the rate divider, one quotient bit per cycle
// in the divider, and the commit, which waits for a free output register and the
// end of the history pass. The first sample after reset skips the divider. A
// result waits in an output register, so the next sample is accepted while it is pending.
module accel_swing_clash_detector_core #(
    parameter int HISTORY_DEPTH = ascd_pkg::DEF_HISTORY_DEPTH,
    parameter int ADC_BITS      = ascd_pkg::DEF_ADC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // sample_time, accel_x, accel_y, accel_z
    input  logic [((ascd_pkg::TIME_W + 3 * ADC_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // clash, swing, swing_level
    output logic [ascd_pkg::OUT_W-1:0]      m_axis_tdata,
    input  logic                            cfg_we,
    input  logic [ascd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ascd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int TW = ascd_pkg::TIME_W;

    ascd_pkg::cmd_t    cmd;
    ascd_pkg::status_t status;

    logic                         clash;
    logic                         swing;
    logic [ascd_pkg::LEVEL_W-1:0] swing_level;

    ascd_ctrl #(
        .ADC_BITS (ADC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ascd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .ADC_BITS      (ADC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_time (s_axis_tdata[TW-1:0]),
        .accel_x     (s_axis_tdata[TW +: ADC_BITS]),
        .accel_y     (s_axis_tdata[TW + ADC_BITS +: ADC_BITS]),
        .accel_z     (s_axis_tdata[TW + 2 * ADC_BITS +: ADC_BITS]),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .cmd         (cmd),
        .status      (status),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .clash       (clash),
        .swing       (swing),
        .swing_level (swing_level)
    );

    assign m_axis_tdata = {{(ascd_pkg::OUT_W - ascd_pkg::LEVEL_W - 2){1'b0}},
                           swing_level, swing, clash};

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !status.dup |=> !s_axis_tready)
        else $error("input taken while a sample is still being processed");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> status.out_free && !status.scan_busy)
        else $error("result committed over a pending result or unfinished history pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(clash && swing))
        else $error("clash and swing reported together");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> swing_level != 2'b11)
        else $error("invalid swing level");
`endif

endmodule

/* tb/tb_accel_swing_clash_detector_core.sv */
`timescale 1ns / 1ps

module tb_accel_swing_clash_detector_core;

    import ascd_pkg::*;

    localparam int ADC_W     = DEF_ADC_BITS;
    localparam int IN_W      = ((TIME_W + 3 * ADC_W + 7) / 8) * 8;
    localparam int RATE_SLOTS = DEF_HISTORY_DEPTH - 1;
    localparam int SETTLE_CYCLES = 60;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int ITEMS_PER_SET = 195;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST = 3'd7;

    typedef struct packed {
        logic [TIME_W-1:0] sample_time;
        logic [ADC_W-1:0]  accel_x;
        logic [ADC_W-1:0]  accel_y;
        logic [ADC_W-1:0]  accel_z;
    } sample_t;

    typedef struct packed {
        logic               clash;
        logic               swing;
        logic [LEVEL_W-1:0] swing_level;
    } event_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_W-1:0]      m_axis_tdata;

    // Shadow copy of the detector's registers and history.
    logic [CFG_DATA_W-1:0] clash_thr;
    logic [CFG_DATA_W-1:0] small_thr;
    logic [CFG_DATA_W-1:0] medium_thr;
    logic [CFG_DATA_W-1:0] large_thr;
    logic [CFG_DATA_W-1:0] holdoff_ms;
    logic [31:0]           rate_hist [RATE_SLOTS];
    int unsigned           rate_fill;
    int unsigned           sample_fill;
    logic [31:0]           prev_magnitude;
    logic [TIME_W-1:0]     prev_time;
    logic [TIME_W-1:0]     clash_time;
    logic [LEVEL_W-1:0]    held_size;

    event_t                pending_events[$];
    int unsigned           send_idle_pct = 0;
    int unsigned           recv_idle_pct = 0;
    int unsigned           fail_count = 0;
    int unsigned           cycle_count = 0;
    logic [ADC_W-1:0]      walk_x = '0;
    logic [ADC_W-1:0]      walk_y = '0;
    logic [ADC_W-1:0]      walk_z = '0;

    accel_swing_clash_detector_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] floor_sqrt(input logic [31:0] v);
        logic [31:0] root;
        logic [31:0] probe;
        root = '0;
        for (int b = 15; b >= 0; b--)
        begin
            probe = root | (32'd1 << b);
            if (64'(probe) * 64'(probe) <= 64'(v))
                root = probe;
        end
        return root;
    endfunction

    function automatic logic [31:0] magnitude_of(input sample_t s);
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
        sx = 32'(s.accel_x) * AXIS_SCALE;
        sy = 32'(s.accel_y) * AXIS_SCALE;
        sz = 32'(s.accel_z) * AXIS_SCALE;
        return floor_sqrt(sx * sx + sy * sy + sz * sz);
    endfunction

    // Advances the shadow state by one sample; returns 0 for a dropped repeat.
    function automatic logic detect_motion(input sample_t s, output event_t ev);
        logic [31:0]       mag;
        logic [31:0]       diff;
        logic [TIME_W-1:0] since;
        logic [31:0]       peak;
        logic              all_fast;
        ev = '0;
        if (sample_fill > 0 && s.sample_time == prev_time)
            return 1'b0;
        mag = magnitude_of(s);
        if (sample_fill > 0)
        begin
            diff = (mag >= prev_magnitude) ? mag - prev_magnitude : prev_magnitude - mag;
            for (int i = RATE_SLOTS - 1; i > 0; i--)
                rate_hist[i] = rate_hist[i - 1];
            rate_hist[0] = diff / (s.sample_time - prev_time);
            if (rate_fill < RATE_SLOTS)
                rate_fill++;
        end
        if (sample_fill < DEF_HISTORY_DEPTH)
            sample_fill++;
        prev_magnitude = mag;
        prev_time = s.sample_time;
        if (sample_fill >= 2 && rate_fill >= 1)
        begin
            since = s.sample_time - clash_time;
            if (rate_hist[0] > clash_thr && since >= holdoff_ms)
            begin
                ev.clash = 1'b1;
                clash_time = s.sample_time;
            end
            else if (since > holdoff_ms)
            begin
                all_fast = 1'b1;
                peak = '0;
                for (int i = 0; i < rate_fill; i++)
                begin
                    if (rate_hist[i] < small_thr)
                        all_fast = 1'b0;
                    if (rate_hist[i] > peak)
                        peak = rate_hist[i];
                end
                if (all_fast)
                begin
                    ev.swing = 1'b1;
                    held_size = LEVEL_SMALL;
                    if (peak >= medium_thr)
                        held_size = LEVEL_MEDIUM;
                    if (peak >= large_thr)
                        held_size = LEVEL_LARGE;
                end
            end
        end
        ev.swing_level = held_size;
        return 1'b1;
    endfunction

    function automatic logic [ADC_W-1:0] nudge(input logic [ADC_W-1:0] a,
                                               input int unsigned span);
        int v;
        v = int'(a) + int'($urandom_range(2 * span)) - int'(span);
        if (v < 0)
            v = 0;
        if (v > (1 << ADC_W) - 1)
            v = (1 << ADC_W) - 1;
        return ADC_W'(v);
    endfunction

    always @(posedge clk)
    begin
        event_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_tready)
            begin
                if (pending_events.size() == 0)
                begin
                    $error("result transfer with no result pending: %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (m_axis_tdata[0] !== want.clash)
                    begin
                        $error("clash mismatch: expected %0d, actual %0d",
                               want.clash, m_axis_tdata[0]);
                        fail_count++;
                    end
                    if (m_axis_tdata[1] !== want.swing)
                    begin
                        $error("swing mismatch: expected %0d, actual %0d",
                               want.swing, m_axis_tdata[1]);
                        fail_count++;
                    end
                    if (m_axis_tdata[3:2] !== want.swing_level)
                    begin
                        $error("swing_level mismatch: expected %0d, actual %0d",
                               want.swing_level, m_axis_tdata[3:2]);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_sample(input sample_t s);
        event_t ev;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({s.accel_z, s.accel_y, s.accel_x, s.sample_time});
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (detect_motion(s, ev))
            pending_events.push_back(ev);
    endtask

    task automatic send_fields(input logic [TIME_W-1:0] t, input logic [ADC_W-1:0] x,
                               input logic [ADC_W-1:0] y, input logic [ADC_W-1:0] z);
        sample_t s;
        s.sample_time = t;
        s.accel_x = x;
        s.accel_y = y;
        s.accel_z = z;
        send_sample(s);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_CLASH_THRESHOLD: clash_thr  = val;
            REG_SWING_SMALL:     small_thr  = val;
            REG_SWING_MEDIUM:    medium_thr = val;
            REG_SWING_LARGE:     large_thr  = val;
            REG_CLASH_HOLDOFF:   holdoff_ms = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input int unsigned flavor);
        wait_idle();
        case (flavor)
            1:
            begin
                write_reg(REG_CLASH_THRESHOLD, CFG_DATA_W'($urandom_range(100, 3000)));
                write_reg(REG_SWING_SMALL, CFG_DATA_W'($urandom_range(0, 150)));
                write_reg(REG_SWING_MEDIUM, CFG_DATA_W'($urandom_range(0, 400)));
                write_reg(REG_SWING_LARGE, CFG_DATA_W'($urandom_range(0, 800)));
                write_reg(REG_CLASH_HOLDOFF, CFG_DATA_W'($urandom_range(0, 300)));
            end
            2:
            begin
                write_reg(REG_CLASH_THRESHOLD, '1);
                write_reg(REG_SWING_SMALL, '0);
                write_reg(REG_SWING_MEDIUM, '1);
                write_reg(REG_SWING_LARGE, '0);
                write_reg(REG_CLASH_HOLDOFF, '0);
            end
            3:
            begin
                write_reg(REG_CLASH_THRESHOLD, '0);
                write_reg(REG_SWING_SMALL, '1);
                write_reg(REG_SWING_MEDIUM, '0);
                write_reg(REG_SWING_LARGE, '1);
                write_reg(REG_CLASH_HOLDOFF, '1);
            end
            default:
            begin
                write_reg(REG_CLASH_THRESHOLD, RST_CLASH_THRESHOLD);
                write_reg(REG_SWING_SMALL, RST_SWING_SMALL);
                write_reg(REG_SWING_MEDIUM, RST_SWING_MEDIUM);
                write_reg(REG_SWING_LARGE, RST_SWING_LARGE);
                write_reg(REG_CLASH_HOLDOFF, RST_CLASH_HOLDOFF);
            end
        endcase
    endtask

    task automatic test_reset_defaults();
        send_idle_pct = 24;
        recv_idle_pct = 53;
        send_fields(32'd0, 10'd0, 10'd0, 10'd0);
        send_fields(32'd0, 10'd1023, 10'd1023, 10'd1023);
        send_fields(32'd200, 10'd1023, 10'd1023, 10'd1023);
        send_fields(32'd201, 10'd0, 10'd0, 10'd0);
        send_fields(32'd250, 10'd1023, 10'd0, 10'd0);
        send_fields(32'd120, 10'd0, 10'd0, 10'd0);
        send_fields(32'hFFFF_FFFF, 10'd1023, 10'd1023, 10'd1023);
        send_fields(32'd1, 10'd0, 10'd0, 10'd0);
        send_fields(32'd1, 10'd512, 10'd512, 10'd512);
        send_fields(32'd3, 10'd1023, 10'd0, 10'd0);
        wait_idle();
    endtask

    task automatic test_holdoff_edges();
        logic [TIME_W-1:0] base;
        write_reg(REG_CLASH_THRESHOLD, '0);
        write_reg(REG_CLASH_HOLDOFF, 16'd10);
        write_reg(REG_SWING_SMALL, '0);
        write_reg(REG_SWING_MEDIUM, '1);
        write_reg(REG_SWING_LARGE, '1);
        write_reg(REG_SPARE, '0);
        write_reg(REG_SPARE_LAST, '1);
        base = prev_time + 1000;
        send_fields(base, 10'd0, 10'd0, 10'd0);
        send_fields(base + 10, 10'd512, 10'd0, 10'd0);
        send_fields(base + 20, 10'd0, 10'd0, 10'd0);
        wait_idle();
        write_reg(REG_CLASH_THRESHOLD, '1);
        send_fields(base + 30, 10'd0, 10'd0, 10'd1);
        send_fields(base + 31, 10'd0, 10'd0, 10'd2);
        wait_idle();
        write_reg(REG_SWING_MEDIUM, '0);
        send_fields(base + 40, 10'd0, 10'd0, 10'd3);
        wait_idle();
        write_reg(REG_SWING_LARGE, '0);
        send_fields(base + 50, 10'd0, 10'd0, 10'd4);
        wait_idle();
        write_reg(REG_SWING_SMALL, '1);
        send_fields(base + 60, 10'd1023, 10'd1023, 10'd1023);
        wait_idle();
    endtask

    task automatic test_random_traffic(input int unsigned send_pct,
                                       input int unsigned recv_pct,
                                       input int unsigned edge_flavor);
        sample_t     s;
        int unsigned pick;
        int unsigned span;
        int unsigned flavors [3];
        flavors = '{1, edge_flavor, 0};
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        foreach (flavors[f])
        begin
            load_settings(flavors[f]);
            repeat (ITEMS_PER_SET)
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                    s.sample_time = prev_time;
                else if (pick < 9)
                    s.sample_time = $urandom();
                else
                    s.sample_time = prev_time + $urandom_range(1, 25);
                if ($urandom_range(3) == 0)
                begin
                    walk_x = ADC_W'($urandom());
                    walk_y = ADC_W'($urandom());
                    walk_z = ADC_W'($urandom());
                end
                else
                begin
                    span = $urandom_range(0, 60);
                    walk_x = nudge(walk_x, span);
                    walk_y = nudge(walk_y, span);
                    walk_z = nudge(walk_z, span);
                end
                s.accel_x = walk_x;
                s.accel_y = walk_y;
                s.accel_z = walk_z;
                send_sample(s);
            end
        end
        wait_idle();
    endtask

    initial
    begin
        clash_thr      = RST_CLASH_THRESHOLD;
        small_thr      = RST_SWING_SMALL;
        medium_thr     = RST_SWING_MEDIUM;
        large_thr      = RST_SWING_LARGE;
        holdoff_ms     = RST_CLASH_HOLDOFF;
        rate_fill      = 0;
        sample_fill    = 0;
        prev_magnitude = '0;
        prev_time      = '0;
        clash_time     = '0;
        held_size      = LEVEL_SMALL;
        foreach (rate_hist[i])
            rate_hist[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_holdoff_edges();
        test_random_traffic(24, 53, 2);
        test_random_traffic(53, 24, 3);
        test_random_traffic(0, 0, 1);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/ascd_pkg.sv
rtl/ascd_ctrl.sv
rtl/ascd_datapath.sv
rtl/accel_swing_clash_detector_core.sv
tb/tb_accel_swing_clash_detector_core.sv
